### hw/rtl/pgfi_pkg.sv
// Package for the path gap filling interpolator: widths, limits, the heading
// wrap function and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package pgfi_pkg;

   localparam int MAX_INSERT = 63;
   localparam int N_W        = $clog2(MAX_INSERT + 1);
   localparam int M_W        = N_W + 1;
   localparam int NUM_FIELDS = 6;
   localparam int FLD_W      = 3;
   localparam int CNT_W      = 6;
   localparam int ROOT_STEPS = 34;
   localparam int DIV_STEPS  = 33;

   localparam logic signed [21:0] PI_Q     = 22'sd205887;
   localparam logic signed [21:0] TWO_PI_Q = 22'sd411775;

   localparam logic [FLD_W-1:0] FLD_HEADING = 3'd3;
   localparam logic [FLD_W-1:0] FLD_LAST    = 3'd5;

   localparam logic [30:0] MAX_GAP_RESET = 31'd131072;

   typedef struct packed {
      logic             load_in;
      logic             sq_x;
      logic             sq_y;
      logic             root_init;
      logic             root_step;
      logic             search_init;
      logic             search_step;
      logic             div_start;
      logic             div_step;
      logic             div_store;
      logic             lane_adv;
      logic             out_fill;
      logic             out_last;
      logic             commit;
      logic [FLD_W-1:0] fld;
   } pgfi_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic exceed;
      logic search_done;
      logic last_fill;
   } pgfi_status_type;

   // wrap a heading difference into [-pi, pi]
   function automatic logic signed [18:0] wrap_heading(input logic signed [20:0] d);
      logic signed [21:0] v;
      v = {d[20], d};
      for (int i = 0; i < 3; i++) begin
         if (v > PI_Q) begin
            v = v - TWO_PI_Q;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (v < -PI_Q) begin
            v = v + TWO_PI_Q;
         end
      end
      return v[18:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/pgfi_req_if.sv
// Input channel of the path gap filling interpolator: one path point per beat.
// Depends on nothing.
`default_nettype none
interface pgfi_req_if;
   logic        valid;
   logic        ready;
   logic        start_path;
   logic [31:0] arc_pos;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [19:0] heading;
   logic [31:0] curvature;
   logic [31:0] speed;

   modport source (output valid, start_path, arc_pos, pos_x, pos_y, heading, curvature,
                   speed, input ready);
   modport sink (input valid, start_path, arc_pos, pos_x, pos_y, heading, curvature,
                 speed, output ready);
endinterface
`default_nettype wire

### hw/rtl/pgfi_rsp_if.sv
// Result channel of the path gap filling interpolator: one output point per beat.
// Depends on nothing.
`default_nettype none
interface pgfi_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_arc_pos;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [20:0] out_heading;
   logic [31:0] out_curvature;
   logic [31:0] out_speed;
   logic        is_filled;
   logic        last_of_run;

   modport source (output valid, out_arc_pos, out_x, out_y, out_heading, out_curvature,
                   out_speed, is_filled, last_of_run, input ready);
   modport sink (input valid, out_arc_pos, out_x, out_y, out_heading, out_curvature,
                 out_speed, is_filled, last_of_run, output ready);
endinterface
`default_nettype wire

### hw/rtl/pgfi_csr.sv
// APB-style register port holding max_gap.
// Uses pgfi_pkg.
`default_nettype none
module pgfi_csr
   import pgfi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output logic      [30:0] max_gap
);

   logic [30:0] max_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= MAX_GAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 3'd0) begin
         max_gap_ff <= csr_pwdata[30:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 3'd0) ? {1'b0, max_gap_ff} : 32'd0;
   assign max_gap    = max_gap_ff;

endmodule
`default_nettype wire

### hw/rtl/pgfi_dp.sv
// Datapath: point registers, gap squarer, integer square root, insert count
// search, shared divider, interpolation lanes and output register. Uses pgfi_pkg.
`default_nettype none
module pgfi_dp
   import pgfi_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pgfi_cmd_type    cmd,
   output pgfi_status_type      status,
   input  wire logic [30:0]     max_gap,
   input  wire logic [31:0]     in_arc_pos,
   input  wire logic [31:0]     in_pos_x,
   input  wire logic [31:0]     in_pos_y,
   input  wire logic [19:0]     in_heading,
   input  wire logic [31:0]     in_curvature,
   input  wire logic [31:0]     in_speed,
   output logic      [31:0]     out_arc_pos,
   output logic      [31:0]     out_x,
   output logic      [31:0]     out_y,
   output logic      [20:0]     out_heading,
   output logic      [31:0]     out_curvature,
   output logic      [31:0]     out_speed,
   output logic                 is_filled,
   output logic                 last_of_run
);

   logic [31:0] cur_ff  [NUM_FIELDS];
   logic [31:0] prev_ff [NUM_FIELDS];
   logic        have_prev_ff;

   logic [65:0] sqx_ff;
   logic [66:0] d2_ff;
   logic [67:0] rad_ff;
   logic [35:0] rem_ff;
   logic [33:0] root_ff;
   logic [N_W-1:0] n_ff;
   logic [37:0] t_ff;
   logic [32:0] dq_ff;
   logic [M_W-1:0] drem_ff;
   logic        dneg_ff;
   logic [N_W-1:0] k_ff;

   logic [32:0]    q0_ff    [NUM_FIELDS];
   logic [M_W-1:0] r0_ff    [NUM_FIELDS];
   logic           neg_ff   [NUM_FIELDS];
   logic [32:0]    acc_q_ff [NUM_FIELDS];
   logic [M_W-1:0] acc_r_ff [NUM_FIELDS];

   logic [31:0] o_val_ff [NUM_FIELDS];
   logic        o_filled_ff;
   logic        o_last_ff;

   // gap squares
   logic signed [32:0] dx, dy;
   logic [32:0] adx, ady, mul_in;
   logic [65:0] prod;

   assign dx     = {cur_ff[1][31], cur_ff[1]} - {prev_ff[1][31], prev_ff[1]};
   assign dy     = {cur_ff[2][31], cur_ff[2]} - {prev_ff[2][31], prev_ff[2]};
   assign adx    = dx[32] ? 33'(-dx) : 33'(dx);
   assign ady    = dy[32] ? 33'(-dy) : 33'(dy);
   assign mul_in = cmd.sq_y ? ady : adx;
   assign prod   = mul_in * mul_in;

   // square root step
   logic [37:0] rem_t, trial;
   logic        root_ge;
   assign rem_t   = {rem_ff, rad_ff[67:66]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = rem_t >= trial;

   logic [33:0] gap34;
   assign gap34 = {3'b000, max_gap};

   // divider step
   logic [M_W-1:0] m_val;
   logic [M_W:0]   dr_t, dr_sub;
   logic           d_ge;
   assign m_val  = {1'b0, n_ff} + M_W'(1);
   assign dr_t   = {drem_ff, dq_ff[32]};
   assign dr_sub = dr_t - {1'b0, m_val};
   assign d_ge   = dr_t >= {1'b0, m_val};

   // field difference for the selected field
   logic signed [32:0] fdiff, fdelta;
   logic signed [18:0] hwrap;
   always_comb begin
      fdiff = {cur_ff[cmd.fld][31], cur_ff[cmd.fld]} - {prev_ff[cmd.fld][31], prev_ff[cmd.fld]};
      hwrap = wrap_heading(fdiff[20:0]);
      if (cmd.fld == FLD_HEADING) begin
         fdelta = 33'(hwrap);
      end else begin
         fdelta = fdiff;
      end
   end

   // lane advance and output values
   logic [32:0]    nq    [NUM_FIELDS];
   logic [M_W-1:0] nr    [NUM_FIELDS];
   logic [31:0]    fillv [NUM_FIELDS];
   always_comb begin
      logic [M_W:0]  rs;
      logic          cy;
      logic [33:0]   sq, sum;
      for (int f = 0; f < NUM_FIELDS; f++) begin
         rs    = {1'b0, acc_r_ff[f]} + {1'b0, r0_ff[f]};
         cy    = rs >= {1'b0, m_val};
         nr[f] = cy ? M_W'(rs - {1'b0, m_val}) : rs[M_W-1:0];
         nq[f] = acc_q_ff[f] + q0_ff[f] + {32'd0, cy};
         sq    = neg_ff[f] ? 34'(-{1'b0, nq[f]}) : {1'b0, nq[f]};
         sum   = {{2{prev_ff[f][31]}}, prev_ff[f]} + sq;
         fillv[f] = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         for (int f = 0; f < NUM_FIELDS; f++) begin
            prev_ff[f] <= 32'd0;
         end
      end else if (cmd.commit) begin
         have_prev_ff <= 1'b1;
         for (int f = 0; f < NUM_FIELDS; f++) begin
            prev_ff[f] <= cur_ff[f];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_ff[0] <= in_arc_pos;
         cur_ff[1] <= in_pos_x;
         cur_ff[2] <= in_pos_y;
         cur_ff[3] <= {{12{in_heading[19]}}, in_heading};
         cur_ff[4] <= in_curvature;
         cur_ff[5] <= in_speed;
      end
      if (cmd.sq_x) begin
         sqx_ff <= prod;
      end
      if (cmd.sq_y) begin
         d2_ff <= {1'b0, sqx_ff} + {1'b0, prod};
      end
      if (cmd.root_init) begin
         rad_ff  <= {1'b0, d2_ff};
         rem_ff  <= 36'd0;
         root_ff <= 34'd0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[65:0], 2'b00};
         rem_ff  <= root_ge ? 36'(rem_t - trial) : rem_t[35:0];
         root_ff <= {root_ff[32:0], root_ge};
      end
      if (cmd.search_init) begin
         n_ff <= N_W'(1);
         t_ff <= {6'd0, max_gap, 1'b0};
         k_ff <= '0;
      end else if (cmd.search_step) begin
         n_ff <= n_ff + N_W'(1);
         t_ff <= t_ff + {7'd0, max_gap};
      end else if (cmd.lane_adv) begin
         k_ff <= k_ff + N_W'(1);
      end
      if (cmd.div_start) begin
         dq_ff   <= fdelta[32] ? 33'(-fdelta) : 33'(fdelta);
         dneg_ff <= fdelta[32];
         drem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff   <= {dq_ff[31:0], d_ge};
         drem_ff <= d_ge ? dr_sub[M_W-1:0] : dr_t[M_W-1:0];
      end
      if (cmd.div_store) begin
         q0_ff[cmd.fld]    <= dq_ff;
         r0_ff[cmd.fld]    <= drem_ff;
         neg_ff[cmd.fld]   <= dneg_ff;
         acc_q_ff[cmd.fld] <= 33'd0;
         acc_r_ff[cmd.fld] <= '0;
      end else if (cmd.lane_adv) begin
         for (int f = 0; f < NUM_FIELDS; f++) begin
            acc_q_ff[f] <= nq[f];
            acc_r_ff[f] <= nr[f];
         end
      end
      if (cmd.out_fill) begin
         for (int f = 0; f < NUM_FIELDS; f++) begin
            o_val_ff[f] <= fillv[f];
         end
         o_filled_ff <= 1'b1;
         o_last_ff   <= 1'b0;
      end else if (cmd.out_last) begin
         for (int f = 0; f < NUM_FIELDS; f++) begin
            o_val_ff[f] <= cur_ff[f];
         end
         o_filled_ff <= 1'b0;
         o_last_ff   <= 1'b1;
      end
   end

   assign status.have_prev   = have_prev_ff;
   assign status.exceed      = (root_ff > gap34) || (root_ff == gap34 && rem_ff != 36'd0);
   assign status.search_done = !(n_ff < N_W'(MAX_INSERT) && t_ff <= {4'd0, root_ff});
   assign status.last_fill   = ({1'b0, k_ff} + M_W'(1)) == {1'b0, n_ff};

   assign out_arc_pos   = o_val_ff[0];
   assign out_x         = o_val_ff[1];
   assign out_y         = o_val_ff[2];
   assign out_heading   = o_val_ff[3][20:0];
   assign out_curvature = o_val_ff[4];
   assign out_speed     = o_val_ff[5];
   assign is_filled     = o_filled_ff;
   assign last_of_run   = o_last_ff;

endmodule
`default_nettype wire

### hw/rtl/pgfi_ctrl.sv
// Controller: sequences one input point through square root, count search,
// divides and emission of the result beats. Uses pgfi_pkg.
`default_nettype none
module pgfi_ctrl
   import pgfi_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_start_path,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire pgfi_status_type status,
   output pgfi_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQX, S_SQY, S_RINIT, S_ROOT, S_CHECK, S_SEARCH,
      S_DSTART, S_DIV, S_DEND, S_FILL, S_LAST
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [FLD_W-1:0] fld_ff;
   logic             rsp_valid_ff;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.fld         = fld_ff;
      cmd.load_in     = (state_ff == S_IDLE) && req_valid;
      cmd.sq_x        = (state_ff == S_SQX);
      cmd.sq_y        = (state_ff == S_SQY);
      cmd.root_init   = (state_ff == S_RINIT);
      cmd.root_step   = (state_ff == S_ROOT);
      cmd.search_init = (state_ff == S_CHECK) && status.exceed;
      cmd.search_step = (state_ff == S_SEARCH) && !status.search_done;
      cmd.div_start   = (state_ff == S_DSTART);
      cmd.div_step    = (state_ff == S_DIV);
      cmd.div_store   = (state_ff == S_DEND);
      cmd.lane_adv    = (state_ff == S_FILL) && slot_free;
      cmd.out_fill    = (state_ff == S_FILL) && slot_free;
      cmd.out_last    = (state_ff == S_LAST) && slot_free;
      cmd.commit      = (state_ff == S_LAST) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_fill || cmd.out_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_start_path || !status.have_prev) ? S_LAST : S_SQX;
               end
            end
            S_SQX: begin
               state_ff <= S_SQY;
            end
            S_SQY: begin
               state_ff <= S_RINIT;
            end
            S_RINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               state_ff <= status.exceed ? S_SEARCH : S_LAST;
            end
            S_SEARCH: begin
               if (status.search_done) begin
                  fld_ff   <= '0;
                  state_ff <= S_DSTART;
               end
            end
            S_DSTART: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_DEND;
               end
            end
            S_DEND: begin
               if (fld_ff == FLD_LAST) begin
                  state_ff <= S_FILL;
               end else begin
                  fld_ff   <= fld_ff + FLD_W'(1);
                  state_ff <= S_DSTART;
               end
            end
            S_FILL: begin
               if (slot_free && status.last_fill) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### hw/rtl/path_gap_filling_interpolator.sv
// Path gap filling interpolator: inserts linearly interpolated points where
// the gap between consecutive path points exceeds max_gap.
// A path start beat, or any point with no previous point, goes straight to the output;
// any other point runs a gap test (squares, 34-step root) and leaves alone if no fill
// is needed, else n + 1 beats leave after the count search and six divides.
// Throughput: one point at a time; reset clears state, the previous point, max_gap to 2.0 m.
`default_nettype none
module path_gap_filling_interpolator
   import pgfi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   pgfi_req_if.sink         req_bus,
   pgfi_rsp_if.source       rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [30:0]     max_gap;
   pgfi_cmd_type    cmd;
   pgfi_status_type status;

   pgfi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_gap     (max_gap)
   );

   pgfi_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_start_path (req_bus.start_path),
      .req_ready      (req_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .status         (status),
      .cmd            (cmd)
   );

   pgfi_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .max_gap       (max_gap),
      .in_arc_pos    (req_bus.arc_pos),
      .in_pos_x      (req_bus.pos_x),
      .in_pos_y      (req_bus.pos_y),
      .in_heading    (req_bus.heading),
      .in_curvature  (req_bus.curvature),
      .in_speed      (req_bus.speed),
      .out_arc_pos   (rsp_bus.out_arc_pos),
      .out_x         (rsp_bus.out_x),
      .out_y         (rsp_bus.out_y),
      .out_heading   (rsp_bus.out_heading),
      .out_curvature (rsp_bus.out_curvature),
      .out_speed     (rsp_bus.out_speed),
      .is_filled     (rsp_bus.is_filled),
      .last_of_run   (rsp_bus.last_of_run)
   );

endmodule
`default_nettype wire
